// File: hdl/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg: shared types and constants of the integer to ASCII formatter
// Word layouts of the request and response channels, digit geometry and the
// character codes used while emitting text.
// ----------------------------------------------------------------------------
package ita_pkg;

   localparam int VALUE_W           = 32;
   localparam int PAD_WIDTH_W       = 5;
   localparam int DIGIT_W           = 4;
   localparam int NUM_DIGITS        = 10;
   localparam int BCD_W             = NUM_DIGITS * DIGIT_W;
   localparam int ND_W              = $clog2(NUM_DIGITS + 1);
   localparam int MAX_WIDTH_DEFAULT = 31;

   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_MINUS  = 8'h2d;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_HEX_A  = 8'h61;

   typedef struct packed {
      logic [VALUE_W-1:0]     value;
      logic                   signed_mode;
      logic                   hex_base;
      logic                   zero_pad;
      logic [PAD_WIDTH_W-1:0] pad_width;
   } ita_req_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } ita_rsp_type;

   // Converted number handed from the converter to the emitter
   typedef struct packed {
      logic [BCD_W-1:0] digits;
      logic             neg;
      logic             zero_pad;
   } ita_num_type;

   // Map one digit (0-15) to its lower-case ASCII character
   function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [7:0] c;
      if (d < DIGIT_W'(10)) begin
         c = CHAR_ZERO + 8'(d);
      end else begin
         c = CHAR_HEX_A + 8'(d - DIGIT_W'(10));
      end
      return c;
   endfunction

endpackage

// File: hdl/ita_dabble.sv
// ----------------------------------------------------------------------------
// ita_dabble: bit-serial binary to digit converter
// Shifts the magnitude into a BCD register one bit per cycle (double dabble)
// for decimal, or loads the nibbles directly for hexadecimal.
// ----------------------------------------------------------------------------
module ita_dabble import ita_pkg::*; #(
   parameter int WIDTH_W = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  ita_req_type        req,
   input  logic [WIDTH_W-1:0] sat_width,
   output logic               busy,
   output logic               done,
   output ita_num_type        num,
   output logic [WIDTH_W-1:0] width
);

   localparam int CNT_W = $clog2(VALUE_W);

   typedef enum logic [1:0] {
      D_IDLE,
      D_SHIFT,
      D_DONE
   } dab_state_type;

   dab_state_type      state_ff;
   logic [BCD_W-1:0]   bcd_ff;
   logic [VALUE_W-1:0] shift_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               neg_ff;
   logic               zpad_ff;
   logic [WIDTH_W-1:0] width_ff;

   logic [BCD_W-1:0]   bcd_adj;
   logic               neg_in;
   logic [VALUE_W-1:0] mag_in;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
         end else begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   assign neg_in = req.signed_mode & ~req.hex_base & req.value[VALUE_W-1];
   assign mag_in = neg_in ? (VALUE_W'(0) - req.value) : req.value;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         case (state_ff)
            D_IDLE: begin
               if (start) begin
                  neg_ff   <= neg_in;
                  zpad_ff  <= req.zero_pad;
                  width_ff <= sat_width;
                  if (req.hex_base) begin
                     bcd_ff   <= {(BCD_W - VALUE_W)'(0), req.value};
                     state_ff <= D_DONE;
                  end else begin
                     bcd_ff   <= '0;
                     shift_ff <= mag_in;
                     count_ff <= CNT_W'(VALUE_W - 1);
                     state_ff <= D_SHIFT;
                  end
               end
            end
            D_SHIFT: begin
               bcd_ff   <= {bcd_adj[BCD_W-2:0], shift_ff[VALUE_W-1]};
               shift_ff <= {shift_ff[VALUE_W-2:0], 1'b0};
               count_ff <= count_ff - CNT_W'(1);
               if (count_ff == '0) begin
                  state_ff <= D_DONE;
               end
            end
            D_DONE: begin
               state_ff <= D_IDLE;
            end
            default: begin
               state_ff <= D_IDLE;
            end
         endcase
      end
   end

   assign busy         = (state_ff != D_IDLE);
   assign done         = (state_ff == D_DONE);
   assign num.digits   = bcd_ff;
   assign num.neg      = neg_ff;
   assign num.zero_pad = zpad_ff;
   assign width        = width_ff;

endmodule

// File: hdl/ita_emit.sv
// ----------------------------------------------------------------------------
// ita_emit: character sequencer
// Drops leading zero digits, then emits the sign and zero padding, or space padding and
// the sign, then the digits, one character per word through a registered output stage.
// ----------------------------------------------------------------------------
module ita_emit import ita_pkg::*; #(
   parameter int WIDTH_W = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  ita_num_type        num,
   input  logic [WIDTH_W-1:0] width,
   output logic               busy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ita_rsp_type        rsp_payload
);

   typedef enum logic [2:0] {
      E_IDLE,
      E_SKIP,
      E_SIGN_Z,
      E_PAD,
      E_SIGN_S,
      E_DIGIT
   } emit_state_type;

   emit_state_type     state_ff;
   logic [BCD_W-1:0]   dig_ff;
   logic [ND_W-1:0]    nd_ff;
   logic               neg_ff;
   logic               zpad_ff;
   logic [WIDTH_W-1:0] width_ff;
   logic [WIDTH_W-1:0] pad_ff;
   logic               rsp_valid_ff;
   ita_rsp_type        rsp_data_ff;

   logic               can_load;
   logic               char_load;
   logic [ND_W-1:0]    len;
   logic [WIDTH_W-1:0] pad_in;
   logic [DIGIT_W-1:0] top_digit;

   assign can_load  = ~rsp_valid_ff | ~rsp_stall;
   assign top_digit = dig_ff[BCD_W-1 -: DIGIT_W];
   assign len       = nd_ff + ND_W'(neg_ff);
   assign pad_in    = (width_ff > WIDTH_W'(len)) ? (width_ff - WIDTH_W'(len)) : '0;

   // a character enters the output register this cycle
   always_comb begin
      case (state_ff)
         E_SIGN_Z, E_SIGN_S: begin
            char_load = can_load & neg_ff;
         end
         E_PAD: begin
            char_load = can_load & (pad_ff != '0);
         end
         E_DIGIT: begin
            char_load = can_load;
         end
         default: begin
            char_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= E_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // raise valid on a load, drop the word once taken
         if (char_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            E_IDLE: begin
               if (start) begin
                  dig_ff   <= num.digits;
                  nd_ff    <= ND_W'(NUM_DIGITS);
                  neg_ff   <= num.neg;
                  zpad_ff  <= num.zero_pad;
                  width_ff <= width;
                  state_ff <= E_SKIP;
               end
            end
            E_SKIP: begin
               if (top_digit == '0 && nd_ff > ND_W'(1)) begin
                  dig_ff <= {dig_ff[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
                  nd_ff  <= nd_ff - ND_W'(1);
               end else begin
                  pad_ff   <= pad_in;
                  state_ff <= zpad_ff ? E_SIGN_Z : E_PAD;
               end
            end
            E_SIGN_Z: begin
               if (!neg_ff) begin
                  state_ff <= E_PAD;
               end else if (can_load) begin
                  rsp_data_ff.char_code <= CHAR_MINUS;
                  rsp_data_ff.last      <= 1'b0;
                  state_ff              <= E_PAD;
               end
            end
            E_PAD: begin
               if (pad_ff == '0) begin
                  state_ff <= zpad_ff ? E_DIGIT : E_SIGN_S;
               end else if (can_load) begin
                  rsp_data_ff.char_code <= zpad_ff ? CHAR_ZERO : CHAR_SPACE;
                  rsp_data_ff.last      <= 1'b0;
                  pad_ff                <= pad_ff - WIDTH_W'(1);
               end
            end
            E_SIGN_S: begin
               if (!neg_ff) begin
                  state_ff <= E_DIGIT;
               end else if (can_load) begin
                  rsp_data_ff.char_code <= CHAR_MINUS;
                  rsp_data_ff.last      <= 1'b0;
                  state_ff              <= E_DIGIT;
               end
            end
            E_DIGIT: begin
               if (can_load) begin
                  rsp_data_ff.char_code <= digit_char(top_digit);
                  rsp_data_ff.last      <= (nd_ff == ND_W'(1));
                  dig_ff                <= {dig_ff[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
                  nd_ff                 <= nd_ff - ND_W'(1);
                  if (nd_ff == ND_W'(1)) begin
                     state_ff <= E_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= E_IDLE;
            end
         endcase
      end
   end

   assign busy        = (state_ff != E_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// File: hdl/integer_to_ascii_formatter.sv
// Decimal: the serial converter shifts in every bit of the magnitude, then the sequencer
//   drops leading zero digits before the first character is emitted; hex loads its nibbles directly.
// A new word is taken the cycle after the last character loads; the serial converter and
//   one character a cycle while the response does not stall set the pace, plus response stalls.
// Reset: synchronous, active high; clears both sequencers and the output valid.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: 32-bit integer to ASCII text
// Converts an operand to signed or unsigned decimal or lower-case hex and
// emits its characters most significant first, one per response word, with
// space or zero padding up to a minimum width.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter import ita_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ita_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ita_rsp_type rsp_payload
);

   // width of the saturated minimum-width count
   localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
   // compare domain wide enough for both the field and the limit
   localparam int CMP_W   = (WIDTH_W > PAD_WIDTH_W) ? WIDTH_W : PAD_WIDTH_W;

   logic               req_accept;
   logic [WIDTH_W-1:0] sat_width;
   logic               dab_busy;
   logic               dab_done;
   ita_num_type        dab_num;
   logic [WIDTH_W-1:0] dab_width;
   logic               emit_busy;

   // Hold off new words while a conversion or its text is in flight. The
   // last character may still wait in the output register; the next word is
   // taken anyway since the converter runs independently of the output.
   assign req_stall  = dab_busy | emit_busy;
   assign req_accept = req_valid & ~req_stall;

   // Saturate the minimum width at the limit
   assign sat_width = (CMP_W'(req_payload.pad_width) > CMP_W'(MAX_WIDTH)) ?
                      WIDTH_W'(MAX_WIDTH) : WIDTH_W'(req_payload.pad_width);

   // Serial binary to digit conversion, one bit per cycle for decimal; hex loads directly
   ita_dabble #(
      .WIDTH_W (WIDTH_W)
   ) u_dabble (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .req       (req_payload),
      .sat_width (sat_width),
      .busy      (dab_busy),
      .done      (dab_done),
      .num       (dab_num),
      .width     (dab_width)
   );

   // Character sequencer: strip leading zeros, sign and padding in either order, digits
   ita_emit #(
      .WIDTH_W (WIDTH_W)
   ) u_emit (
      .clock       (clock),
      .reset       (reset),
      .start       (dab_done),
      .num         (dab_num),
      .width       (dab_width),
      .busy        (emit_busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
